/* hdl/sorted_insertion_priority_list_core_defines.svh */
// Assertion macros shared by the priority list RTL.
`ifndef SORTED_INSERTION_PRIORITY_LIST_CORE_DEFINES_SVH
`define SORTED_INSERTION_PRIORITY_LIST_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Clocked property, disabled while reset is high
`define SIPL_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Clocked property, checked during reset as well
`define SIPL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SIPL_ASSERT(lbl, clk, rst, prop, msg)
`define SIPL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* hdl/sipl_pkg.sv */
// Types and constants of the sorted insertion priority list.
package sipl_pkg;

  localparam int DEPTH    = 16;
  localparam int KEY_BITS = 16;
  localparam int ID_BITS  = 8;
  localparam int COUNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W    = $clog2(DEPTH);

  // Command codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DUMP   = 2'd1,
    OP_CLEAR  = 2'd2
  } sipl_op_e;

  // Result codes
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_ENTRY  = 2'd1,
    KIND_CLEAR  = 2'd2
  } sipl_kind_e;

  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } sipl_state_e;

  typedef struct packed {
    logic [1:0]                 op;
    logic [ID_BITS-1:0]         entity_index;
    logic signed [KEY_BITS-1:0] priority_key;
  } sipl_in_t;

  typedef struct packed {
    logic [1:0]                 result_kind;
    logic                       status;
    logic                       entry_valid;
    logic [ID_BITS-1:0]         out_entity_index;
    logic signed [KEY_BITS-1:0] out_priority_key;
    logic [COUNT_W-1:0]         entry_count;
    logic                       last;
  } sipl_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic             insert;
    logic             clear;
    logic             empty_dump;
    logic             entry_load;
    logic             entry_last;
    logic [IDX_W-1:0] ptr;
  } sipl_ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic [COUNT_W-1:0] count;
  } sipl_sts_t;

endpackage

/* hdl/sorted_insertion_priority_list_core.sv */
// Insert or clear: result in the cycle after acceptance; one transaction per cycle.
// Dump of N entries: busy during the dump state, which walks the N entries with the
// dump pointer; entries appear one per cycle, each registered into the result.
// Empty dump: one invalid entry in the cycle after acceptance.
// Synchronous reset empties the list; entry storage itself is not cleared.
// Results cannot be stalled by the receiver.
module sorted_insertion_priority_list_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  sipl_pkg::sipl_in_t  cmd,
  output logic                result_valid,
  output sipl_pkg::sipl_out_t result
);
  import sipl_pkg::*;

  sipl_ctl_t ctl;
  sipl_sts_t sts;

  sipl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (cmd.op),
    .sts   (sts),
    .busy  (busy),
    .ctl   (ctl)
  );

  sipl_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .ctl          (ctl),
    .sts          (sts),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

/* hdl/sipl_ctrl.sv */
// Controller: transaction decode and dump sequencing.
`include "sorted_insertion_priority_list_core_defines.svh"

module sipl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         op,
  input  sipl_pkg::sipl_sts_t sts,
  output logic               busy,
  output sipl_pkg::sipl_ctl_t ctl
);
  import sipl_pkg::*;

  sipl_state_e      state, state_next;
  logic [IDX_W-1:0] ptr, ptr_next;
  logic             accept;
  logic             ptr_last;

  assign accept   = start && !busy;
  assign ptr_last = (COUNT_W'(ptr) == (sts.count - COUNT_W'(1)));

  // State and dump pointer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ptr   <= '0;
    end else begin
      state <= state_next;
      ptr   <= ptr_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    ptr_next   = ptr;
    unique case (state)
      ST_IDLE: begin
        ptr_next = '0;
        if (accept && (op == OP_DUMP) && (sts.count != '0)) state_next = ST_DUMP;
      end
      ST_DUMP: begin
        ptr_next = ptr + IDX_W'(1);
        if (ptr_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    busy           = 1'b0;
    ctl            = '0;
    ctl.ptr        = ptr;
    ctl.entry_last = ptr_last;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          ctl.insert     = (op == OP_INSERT);
          ctl.clear      = (op == OP_CLEAR);
          ctl.empty_dump = (op == OP_DUMP) && (sts.count == '0);
        end
      end
      ST_DUMP: begin
        busy           = 1'b1;
        ctl.entry_load = 1'b1;
      end
      default: busy = 1'b0;
    endcase
  end

  `SIPL_ASSERT(a_ptr_in_range, clk, rst,
    (state == ST_DUMP) |-> (COUNT_W'(ptr) < sts.count), "dump pointer beyond fill count")
  `SIPL_ASSERT(a_dump_entry, clk, rst,
    (accept && (op == OP_DUMP) && (sts.count != '0)) |=> ((state == ST_DUMP) && (ptr == '0)),
    "dump did not start at first entry")
  `SIPL_ASSERT(a_dump_exit, clk, rst,
    ((state == ST_DUMP) && ptr_last) |=> (state == ST_IDLE), "dump did not end on last entry")

endmodule

/* hdl/sipl_dp.sv */
// Datapath: sorted entry cells, fill count and result register.
`include "sorted_insertion_priority_list_core_defines.svh"

module sipl_dp (
  input  logic                clk,
  input  logic                rst,
  input  sipl_pkg::sipl_in_t  cmd,
  input  sipl_pkg::sipl_ctl_t ctl,
  output sipl_pkg::sipl_sts_t sts,
  output sipl_pkg::sipl_out_t result,
  output logic                result_valid
);
  import sipl_pkg::*;

  logic signed [KEY_BITS-1:0] keys [DEPTH];
  logic [ID_BITS-1:0]         ids  [DEPTH];
  logic [COUNT_W-1:0]         count;
  logic                       full;
  logic [DEPTH-1:0]           ge;
  logic [DEPTH-1:0]           sel_new;
  logic signed [KEY_BITS-1:0] shift_key [DEPTH];
  logic [ID_BITS-1:0]         shift_id  [DEPTH];
  logic [DEPTH-2:0]           pair_ok;
  logic                       order_ok;
  sipl_out_t                  res_next;

  assign full      = (count == COUNT_W'(DEPTH));
  assign sts.count = count;

  // Each occupied cell compares its key against the new one
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge[i] = (COUNT_W'(i) < count) && (keys[i] >= cmd.priority_key);
    end
  end

  // Cells: keep, take the new entry, or take the neighbour's entry
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign sel_new[g]   = !ge[g];
      assign shift_key[g] = cmd.priority_key;
      assign shift_id[g]  = cmd.entity_index;
    end else begin : g_body
      assign sel_new[g]   = !ge[g] && ge[g-1];
      assign shift_key[g] = keys[g-1];
      assign shift_id[g]  = ids[g-1];
    end

    always_ff @(posedge clk) begin
      if (ctl.insert && !full && !ge[g]) begin
        keys[g] <= sel_new[g] ? cmd.priority_key : shift_key[g];
        ids[g]  <= sel_new[g] ? cmd.entity_index : shift_id[g];
      end
    end
  end

  // Neighbouring occupied cells stay in descending key order
  for (genvar g = 0; g < DEPTH - 1; g++) begin : g_order
    assign pair_ok[g] = !(COUNT_W'(g + 1) < count) || (keys[g] >= keys[g+1]);
  end
  assign order_ok = &pair_ok;

  // Next result
  always_comb begin
    res_next             = '0;
    res_next.result_kind = KIND_INSERT;
    res_next.entry_count = count;
    res_next.last        = 1'b1;
    if (ctl.insert) begin
      res_next.status      = full;
      res_next.entry_count = full ? count : count + COUNT_W'(1);
    end
    if (ctl.clear) begin
      res_next.result_kind = KIND_CLEAR;
      res_next.entry_count = '0;
    end
    if (ctl.empty_dump) begin
      res_next.result_kind = KIND_ENTRY;
    end
    if (ctl.entry_load) begin
      res_next.result_kind      = KIND_ENTRY;
      res_next.entry_valid      = 1'b1;
      res_next.out_entity_index = ids[ctl.ptr];
      res_next.out_priority_key = keys[ctl.ptr];
      res_next.last             = ctl.entry_last;
    end
  end

  // Fill count and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctl.insert || ctl.clear || ctl.empty_dump || ctl.entry_load;
      if (ctl.clear) begin
        count <= '0;
      end else if (ctl.insert && !full) begin
        count <= count + COUNT_W'(1);
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    result <= res_next;
  end

  `SIPL_ASSERT(a_count_bound, clk, rst,
    count <= COUNT_W'(DEPTH), "fill count above depth")
  `SIPL_ASSERT(a_sorted, clk, rst,
    order_ok, "stored entries out of order")
  `SIPL_ASSERT(a_drop_when_full, clk, rst,
    (result_valid && result.status) |-> (result.entry_count == COUNT_W'(DEPTH)),
    "insert dropped while list not full")

endmodule
